[src/assert_macros.svh]
// Assertion macros used by grammar_token_lexer_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check clocked on i_clk, held off while reset is asserted.
`define GTL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check clocked on i_clk, live during reset as well.
`define GTL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/gtl_pkg.sv]
// Types, constants and helpers for the grammar token lexer.
package gtl_pkg;

    // Lexeme counter limit and widths
    localparam int unsigned MAX_LEXEME = 4095;
    localparam int unsigned CNT_W      = $clog2(MAX_LEXEME + 1);
    localparam int unsigned LEN_W      = 12;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Result queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    // Token kinds
    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_BLANK  = 4'd1,
        K_STAR   = 4'd2,
        K_PLUS   = 4'd3,
        K_ANY    = 4'd4,
        K_TERM   = 4'd5,
        K_BAR    = 4'd6,
        K_LPAR   = 4'd7,
        K_RPAR   = 4'd8,
        K_ARROW  = 4'd9,
        K_SYMBOL = 4'd10,
        K_SET    = 4'd11,
        K_LIT    = 4'd12,
        K_CMT    = 4'd13,
        K_UNTERM = 4'd14
    } t_kind;

    // Input request
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in;

    // Result token
    typedef struct packed {
        t_kind            token_kind;
        logic [LEN_W-1:0] lexeme_length;
        logic             length_overflow;
        logic             last_of_run;
    } t_out;

    // Build a token from the running count, saturating the reported length
    function automatic t_out make_tok(t_kind kind, logic [CNT_W-1:0] cnt, logic ovf);
        logic [CNT_W+LEN_W-1:0] ext;
        t_out                   tok;
        ext = {{LEN_W{1'b0}}, cnt};
        tok.token_kind  = kind;
        tok.last_of_run = 1'b0;
        if (ext > {{CNT_W{1'b0}}, LEN_MAX}) begin
            tok.lexeme_length   = LEN_MAX;
            tok.length_overflow = 1'b1;
        end else begin
            tok.lexeme_length   = ext[LEN_W-1:0];
            tok.length_overflow = ovf;
        end
        return tok;
    endfunction

endpackage

[src/grammar_token_lexer_unit.sv]
// Grammar token lexer: top level with lexer state and result queue.
//
// Takes one character request per cycle and returns tokens (kind, saturating
// lexeme length, overflow flag, last-of-run flag). All lexing for a request
// is done in one pass of combinational logic from the lexer state registers
// into a 4-entry result queue. A request that closes a symbol and also
// produces a token of its own (or eof) pushes two results; the output side
// drains one result per cycle, and o_ready drops while the queue holds more
// than two results. With the output always ready the block sustains one
// request per cycle; end-of-input inside a set, literal, comment or after a
// lone dash returns an unterminated token.

`include "assert_macros.svh"

module grammar_token_lexer_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gtl_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output gtl_pkg::t_out  o_data
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_DASH = 3'd1,
        M_SYM  = 3'd2,
        M_SET  = 3'd3,
        M_LIT  = 3'd4,
        M_ESC  = 3'd5,
        M_CMT  = 3'd6
    } t_mode;

    // Lexer state
    t_mode                        r_mode,  n_mode;
    logic [gtl_pkg::CNT_W-1:0]    r_cnt,   n_cnt;
    logic                         r_ovf,   n_ovf;

    // Result queue
    gtl_pkg::t_out                r_q [gtl_pkg::Q_DEPTH];
    logic [gtl_pkg::Q_PTR_W-1:0]  r_wr, r_rd;
    logic [gtl_pkg::Q_CNT_W-1:0]  r_qcnt;

    logic                         accept, pop;
    logic [1:0]                   n_tok;
    gtl_pkg::t_out                tok0, tok1;

    assign accept  = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_ready = (r_qcnt <= gtl_pkg::Q_CNT_W'(gtl_pkg::Q_DEPTH - 2));
    assign o_valid = (r_qcnt != '0);
    assign o_data  = r_q[r_rd];

    // Lexer step: at most a symbol close followed by one more token
    always_comb begin
        logic [7:0]                c;
        logic                      eoi;
        logic                      sym_ch;
        logic                      emit_a, emit_b;
        logic                      is_blank;
        logic                      is_op;
        gtl_pkg::t_kind            op_kind;
        gtl_pkg::t_out             tok_a, tok_b;
        t_mode                     mb;

        c        = i_data.char_byte;
        eoi      = i_data.end_of_input;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        tok_a    = '0;
        tok_b    = '0;
        is_blank = 1'b0;
        is_op    = 1'b0;
        op_kind  = gtl_pkg::K_EOF;
        sym_ch   = (c inside {[gtl_pkg::CH_LO_A:gtl_pkg::CH_LO_Z]})
                || (c inside {[gtl_pkg::CH_DIG_0:gtl_pkg::CH_DIG_9]})
                || (c == gtl_pkg::CH_UNDER);
        mb       = r_mode;

        // Phase A: symbol continues or closes
        if (r_mode == M_SYM) begin
            if (!eoi && sym_ch) begin
                if (n_cnt < gtl_pkg::CNT_W'(gtl_pkg::MAX_LEXEME)) begin
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                emit_a = 1'b1;
                tok_a  = gtl_pkg::make_tok(gtl_pkg::K_SYMBOL, n_cnt, n_ovf);
                n_cnt  = '0;
                n_ovf  = 1'b0;
                n_mode = M_IDLE;
                mb     = M_IDLE;
            end
        end

        // Phase B: the request in the mode left by phase A
        if (!(r_mode == M_SYM && !eoi && sym_ch)) begin
            if (eoi) begin
                emit_b = 1'b1;
                if (mb == M_IDLE) begin
                    tok_b = gtl_pkg::make_tok(gtl_pkg::K_EOF, n_cnt, n_ovf);
                end else begin
                    tok_b = gtl_pkg::make_tok(gtl_pkg::K_UNTERM, n_cnt, n_ovf);
                end
                n_cnt  = '0;
                n_ovf  = 1'b0;
                n_mode = M_IDLE;
            end else begin
                case (mb)
                    M_DASH: begin
                        if (c == gtl_pkg::CH_GT) begin
                            if (n_cnt < gtl_pkg::CNT_W'(gtl_pkg::MAX_LEXEME)) begin
                                n_cnt = n_cnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            emit_b = 1'b1;
                            tok_b  = gtl_pkg::make_tok(gtl_pkg::K_ARROW, n_cnt, n_ovf);
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                            n_mode = M_IDLE;
                        end else if (c == gtl_pkg::CH_DASH) begin
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                            n_mode = M_CMT;
                        end
                    end
                    M_SET, M_LIT, M_ESC: begin
                        if (n_cnt < gtl_pkg::CNT_W'(gtl_pkg::MAX_LEXEME)) begin
                            n_cnt = n_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (mb == M_ESC) begin
                            n_mode = M_LIT;
                        end else if (mb == M_SET && c == gtl_pkg::CH_RBRK) begin
                            emit_b = 1'b1;
                            tok_b  = gtl_pkg::make_tok(gtl_pkg::K_SET, n_cnt, n_ovf);
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                            n_mode = M_IDLE;
                        end else if (mb == M_LIT && c == gtl_pkg::CH_QUOTE) begin
                            emit_b = 1'b1;
                            tok_b  = gtl_pkg::make_tok(gtl_pkg::K_LIT, n_cnt, n_ovf);
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                            n_mode = M_IDLE;
                        end else if (mb == M_LIT && c == gtl_pkg::CH_BSL) begin
                            n_mode = M_ESC;
                        end
                    end
                    M_CMT: begin
                        if (c == gtl_pkg::CH_LF) begin
                            emit_b = 1'b1;
                            tok_b  = gtl_pkg::make_tok(gtl_pkg::K_CMT, n_cnt, n_ovf);
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                            n_mode = M_IDLE;
                        end
                    end
                    default: begin
                        // Idle: single-character tokens and lexeme openers
                        n_mode = M_IDLE;
                        case (c)
                            gtl_pkg::CH_SPACE, gtl_pkg::CH_TAB,
                            gtl_pkg::CH_CR, gtl_pkg::CH_LF: is_blank = 1'b1;
                            gtl_pkg::CH_STAR: begin is_op = 1'b1; op_kind = gtl_pkg::K_STAR; end
                            gtl_pkg::CH_PLUS: begin is_op = 1'b1; op_kind = gtl_pkg::K_PLUS; end
                            gtl_pkg::CH_DOT:  begin is_op = 1'b1; op_kind = gtl_pkg::K_ANY;  end
                            gtl_pkg::CH_SEMI: begin is_op = 1'b1; op_kind = gtl_pkg::K_TERM; end
                            gtl_pkg::CH_BAR:  begin is_op = 1'b1; op_kind = gtl_pkg::K_BAR;  end
                            gtl_pkg::CH_LPAR: begin is_op = 1'b1; op_kind = gtl_pkg::K_LPAR; end
                            gtl_pkg::CH_RPAR: begin is_op = 1'b1; op_kind = gtl_pkg::K_RPAR; end
                            default: begin
                                is_op = 1'b0;
                            end
                        endcase
                        if (is_blank) begin
                            emit_b = 1'b1;
                            tok_b  = gtl_pkg::make_tok(gtl_pkg::K_BLANK, n_cnt, n_ovf);
                            n_cnt  = '0;
                            n_ovf  = 1'b0;
                        end else if (is_op || c == gtl_pkg::CH_DASH
                                     || c == gtl_pkg::CH_LBRK || c == gtl_pkg::CH_QUOTE
                                     || (c inside {[gtl_pkg::CH_LO_A:gtl_pkg::CH_LO_Z]})) begin
                            if (n_cnt < gtl_pkg::CNT_W'(gtl_pkg::MAX_LEXEME)) begin
                                n_cnt = n_cnt + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (is_op) begin
                                emit_b = 1'b1;
                                tok_b  = gtl_pkg::make_tok(op_kind, n_cnt, n_ovf);
                                n_cnt  = '0;
                                n_ovf  = 1'b0;
                            end else if (c == gtl_pkg::CH_DASH) begin
                                n_mode = M_DASH;
                            end else if (c == gtl_pkg::CH_LBRK) begin
                                n_mode = M_SET;
                            end else if (c == gtl_pkg::CH_QUOTE) begin
                                n_mode = M_LIT;
                            end else begin
                                n_mode = M_SYM;
                            end
                        end
                    end
                endcase
            end
        end

        // Pack results into queue slots; mark the final one
        tok_a.last_of_run = !emit_b;
        tok_b.last_of_run = 1'b1;
        if (emit_a) begin
            tok0 = tok_a;
            tok1 = tok_b;
        end else begin
            tok0 = tok_b;
            tok1 = tok_b;
        end
        n_tok = {1'b0, emit_a} + {1'b0, emit_b};
    end

    // Lexer state and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_ovf  <= n_ovf;
                r_wr   <= r_wr + gtl_pkg::Q_PTR_W'(n_tok & {2{accept}});
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_qcnt <= r_qcnt + gtl_pkg::Q_CNT_W'(accept ? n_tok : 2'd0)
                             - gtl_pkg::Q_CNT_W'(pop);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (accept && n_tok != 2'd0) begin
            r_q[r_wr] <= tok0;
            if (n_tok == 2'd2) begin
                r_q[r_wr + 1'b1] <= tok1;
            end
        end
    end

    // Checks
    `GTL_ASSERT(a_q_bound, r_qcnt <= gtl_pkg::Q_CNT_W'(gtl_pkg::Q_DEPTH), "result queue overrun")
    `GTL_ASSERT(a_two_only_sym, (accept && n_tok == 2'd2) |-> (r_mode == M_SYM), "two tokens outside symbol close")
    `GTL_ASSERT(a_last_mark, (accept && n_tok == 2'd2) |-> (!tok0.last_of_run && tok1.last_of_run), "bad last-of-run marking")
    `GTL_ASSERT(a_push_seen, (accept && n_tok != 2'd0) |=> o_valid, "pushed token not presented")

endmodule
